// ----- rtl/hps_pkg.sv -----
package hps_pkg;

    localparam int unsigned CountWidth = 8;
    localparam int unsigned CfgIndexWidth = 3;
    localparam int unsigned CfgDataWidth = 8;
    localparam logic [CountWidth-1:0] CountMax = 8'd255;

    typedef enum logic [1:0] {
        ST_OFF      = 2'd0,
        ST_STARTUP  = 2'd1,
        ST_RUNNING  = 2'd2,
        ST_SHUTDOWN = 2'd3
    } seq_state_t;

    typedef enum logic [CfgIndexWidth-1:0] {
        REG_DEBOUNCE_TICKS          = 3'd0,
        REG_HOLD_TICKS              = 3'd1,
        REG_STARTUP_MIN_TICKS       = 3'd2,
        REG_STARTUP_TIMEOUT         = 3'd3,
        REG_SHUTDOWN_RETURN_TICKS   = 3'd4,
        REG_SHUTDOWN_HOST_OFF_TICKS = 3'd5,
        REG_SHUTDOWN_TIMEOUT        = 3'd6,
        REG_BLINK_STEP              = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] debounce_ticks;
        logic [7:0] hold_ticks;
        logic [7:0] startup_min_ticks;
        logic [7:0] startup_timeout;
        logic [7:0] shutdown_return_ticks;
        logic [7:0] shutdown_host_off_ticks;
        logic [7:0] shutdown_timeout;
        logic [6:0] blink_step;
    } cfg_t;

    localparam cfg_t CfgReset = '{
        debounce_ticks:          8'd6,
        hold_ticks:              8'd250,
        startup_min_ticks:       8'd6,
        startup_timeout:         8'd120,
        shutdown_return_ticks:   8'd4,
        shutdown_host_off_ticks: 8'd40,
        shutdown_timeout:        8'd120,
        blink_step:              7'd2
    };

    typedef struct packed {
        logic button_pressed;
        logic host_ready;
        logic fast_tick;
        logic slow_tick;
    } sample_t;

    typedef struct packed {
        logic       supply_on;
        logic       shutdown_request;
        logic       led_lit;
        seq_state_t power_state;
    } status_t;

endpackage

// ----- rtl/hps_sample_if.sv -----
interface hps_sample_if;
    logic valid;
    logic ready;
    logic button_pressed;
    logic host_ready;
    logic fast_tick;
    logic slow_tick;

    modport source (
        output valid,
        output button_pressed,
        output host_ready,
        output fast_tick,
        output slow_tick,
        input  ready
    );

    modport sink (
        input  valid,
        input  button_pressed,
        input  host_ready,
        input  fast_tick,
        input  slow_tick,
        output ready
    );
endinterface

// ----- rtl/hps_status_if.sv -----
interface hps_status_if;
    logic       valid;
    logic       ready;
    logic       supply_on;
    logic       shutdown_request;
    logic       led_lit;
    logic [1:0] power_state;

    modport source (
        output valid,
        output supply_on,
        output shutdown_request,
        output led_lit,
        output power_state,
        input  ready
    );

    modport sink (
        input  valid,
        input  supply_on,
        input  shutdown_request,
        input  led_lit,
        input  power_state,
        output ready
    );
endinterface

// ----- rtl/hps_cfg.sv -----
module hps_cfg (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [hps_pkg::CfgIndexWidth-1:0]     cfg_index,
    input  logic [hps_pkg::CfgDataWidth-1:0]      cfg_data,
    output hps_pkg::cfg_t                         cfg
);

    hps_pkg::cfg_t cfg_reg;
    hps_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (hps_pkg::cfg_index_t'(cfg_index))
                hps_pkg::REG_DEBOUNCE_TICKS:          cfg_next.debounce_ticks = cfg_data;
                hps_pkg::REG_HOLD_TICKS:              cfg_next.hold_ticks = cfg_data;
                hps_pkg::REG_STARTUP_MIN_TICKS:       cfg_next.startup_min_ticks = cfg_data;
                hps_pkg::REG_STARTUP_TIMEOUT:         cfg_next.startup_timeout = cfg_data;
                hps_pkg::REG_SHUTDOWN_RETURN_TICKS:   cfg_next.shutdown_return_ticks = cfg_data;
                hps_pkg::REG_SHUTDOWN_HOST_OFF_TICKS: cfg_next.shutdown_host_off_ticks = cfg_data;
                hps_pkg::REG_SHUTDOWN_TIMEOUT:        cfg_next.shutdown_timeout = cfg_data;
                hps_pkg::REG_BLINK_STEP:              cfg_next.blink_step = cfg_data[6:0];
                default:                              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= hps_pkg::CfgReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/hps_step.sv -----
module hps_step (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  hps_pkg::sample_t sample,
    input  hps_pkg::cfg_t    cfg,
    output hps_pkg::status_t status
);

    hps_pkg::seq_state_t state_reg, state_next;
    logic [7:0] slow_count_reg, slow_count_next;
    logic [7:0] press_count_reg, press_count_next;
    logic       long_seen_reg, long_seen_next;
    logic [7:0] blink_level_reg, blink_level_next;
    logic       blink_falling_reg, blink_falling_next;
    logic [7:0] pwm_phase_reg, pwm_phase_next;
    hps_pkg::status_t status_reg, status_next;

    logic [8:0] level_sum;
    logic [7:0] step8;
    logic       tap_hit;
    logic       hold_hit;
    logic       lit;

    assign step8     = {1'b0, cfg.blink_step};
    assign level_sum = {1'b0, blink_level_reg} + {1'b0, step8};

    always_comb
    begin
        state_next         = state_reg;
        slow_count_next    = slow_count_reg;
        press_count_next   = press_count_reg;
        long_seen_next     = long_seen_reg;
        blink_level_next   = blink_level_reg;
        blink_falling_next = blink_falling_reg;
        pwm_phase_next     = pwm_phase_reg;
        tap_hit            = 1'b0;
        hold_hit           = 1'b0;
        lit                = 1'b0;

        if (sample.fast_tick)
        begin
            // Triangle wave: clamp at the top and bottom and turn around there.
            if (!blink_falling_reg)
            begin
                if (level_sum[8])
                begin
                    blink_falling_next = 1'b1;
                    blink_level_next   = hps_pkg::CountMax;
                end
                else
                begin
                    blink_level_next = level_sum[7:0];
                end
            end
            else
            begin
                if (blink_level_reg < step8)
                begin
                    blink_falling_next = 1'b0;
                    blink_level_next   = '0;
                end
                else
                begin
                    blink_level_next = blink_level_reg - step8;
                end
            end
            if (sample.button_pressed && press_count_reg != hps_pkg::CountMax)
            begin
                press_count_next = press_count_reg + 8'd1;
            end
        end

        if (sample.slow_tick && slow_count_reg != hps_pkg::CountMax)
        begin
            slow_count_next = slow_count_reg + 8'd1;
        end

        if (sample.button_pressed)
        begin
            if (!long_seen_reg && press_count_next >= cfg.hold_ticks)
            begin
                hold_hit       = 1'b1;
                long_seen_next = 1'b1;
            end
        end
        else
        begin
            if (!long_seen_reg && press_count_next >= cfg.debounce_ticks
                && press_count_next != 8'd0)
            begin
                tap_hit = 1'b1;
            end
            press_count_next = '0;
            long_seen_next   = 1'b0;
        end

        case (state_reg)
            hps_pkg::ST_OFF:
            begin
                if (tap_hit)
                begin
                    state_next = hps_pkg::ST_STARTUP;
                end
            end
            hps_pkg::ST_STARTUP:
            begin
                if ((sample.host_ready && slow_count_next >= cfg.startup_min_ticks)
                    || slow_count_next >= cfg.startup_timeout)
                begin
                    state_next = hps_pkg::ST_RUNNING;
                end
            end
            hps_pkg::ST_RUNNING:
            begin
                if (!sample.host_ready || tap_hit)
                begin
                    state_next = hps_pkg::ST_SHUTDOWN;
                end
            end
            default:
            begin
                // Powering off outranks a return to running.
                if (sample.host_ready && slow_count_next >= cfg.shutdown_return_ticks)
                begin
                    state_next = hps_pkg::ST_RUNNING;
                end
                if (!sample.host_ready && slow_count_next >= cfg.shutdown_host_off_ticks)
                begin
                    state_next = hps_pkg::ST_OFF;
                end
                if (slow_count_next >= cfg.shutdown_timeout)
                begin
                    state_next = hps_pkg::ST_OFF;
                end
            end
        endcase

        if (hold_hit)
        begin
            state_next = hps_pkg::ST_OFF;
        end
        if (state_next != state_reg)
        begin
            slow_count_next = '0;
        end

        case (state_next)
            hps_pkg::ST_OFF:
            begin
                blink_level_next   = '0;
                blink_falling_next = 1'b0;
                lit                = 1'b0;
            end
            hps_pkg::ST_RUNNING:
            begin
                blink_level_next   = hps_pkg::CountMax;
                blink_falling_next = 1'b1;
                lit                = 1'b1;
            end
            default:
            begin
                lit            = (pwm_phase_reg >= blink_level_next);
                pwm_phase_next = pwm_phase_reg + 8'd1;
            end
        endcase

        status_next.supply_on        = (state_next != hps_pkg::ST_OFF);
        status_next.shutdown_request = (state_next == hps_pkg::ST_SHUTDOWN);
        status_next.led_lit          = lit;
        status_next.power_state      = state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= hps_pkg::ST_OFF;
            slow_count_reg    <= '0;
            press_count_reg   <= '0;
            long_seen_reg     <= 1'b0;
            blink_level_reg   <= '0;
            blink_falling_reg <= 1'b0;
            pwm_phase_reg     <= '0;
        end
        else if (accept)
        begin
            state_reg         <= state_next;
            slow_count_reg    <= slow_count_next;
            press_count_reg   <= press_count_next;
            long_seen_reg     <= long_seen_next;
            blink_level_reg   <= blink_level_next;
            blink_falling_reg <= blink_falling_next;
            pwm_phase_reg     <= pwm_phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
        end
    end

    assign status = status_reg;

endmodule

// ----- rtl/host_power_sequencer.sv -----
// Channel   Dir   Payload                                            Handshake
// sample    in    button_pressed, host_ready, fast_tick, slow_tick   valid/ready
// status    out   supply_on, shutdown_request, led_lit, power_state  valid/ready
// cfg       in    cfg_index (3 bits), cfg_data (8 bits)              cfg_we only
//
// The whole step is one pass of logic from the state registers into the result register,
// so one sample transaction per clock, unless a full result register that is not drained stalls it.
// The result is registered and appears in the cycle after the sample transaction.
// A new sample is taken whenever the result register is empty or being drained.
// Reset brings the sequencer to off and loads the default register values.
module host_power_sequencer (
    input  logic                              clk,
    input  logic                              rst_n,
    hps_sample_if.sink                        sample,
    hps_status_if.source                      status,
    input  logic                              cfg_we,
    input  logic [hps_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [hps_pkg::CfgDataWidth-1:0]  cfg_data
);

    hps_pkg::cfg_t    cfg;
    hps_pkg::sample_t sample_bus;
    hps_pkg::status_t status_bus;
    logic             accept;
    logic             out_valid_reg, out_valid_next;

    assign sample.ready = !out_valid_reg || status.ready;
    assign accept       = sample.valid && sample.ready;

    assign sample_bus.button_pressed = sample.button_pressed;
    assign sample_bus.host_ready     = sample.host_ready;
    assign sample_bus.fast_tick      = sample.fast_tick;
    assign sample_bus.slow_tick      = sample.slow_tick;

    hps_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hps_step u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .sample (sample_bus),
        .cfg    (cfg),
        .status (status_bus)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (status.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.valid            = out_valid_reg;
    assign status.supply_on        = status_bus.supply_on;
    assign status.shutdown_request = status_bus.shutdown_request;
    assign status.led_lit          = status_bus.led_lit;
    assign status.power_state      = status_bus.power_state;

`ifndef SYNTH
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> status.valid)
        else $error("sample transaction did not produce a result");

    a_off_is_dark: assert property (@(posedge clk) disable iff (!rst_n)
        (status.valid && status.power_state == hps_pkg::ST_OFF)
            |-> (!status.supply_on && !status.led_lit))
        else $error("relay or LED active while powered off");

    a_request_needs_relay: assert property (@(posedge clk) disable iff (!rst_n)
        (status.valid && status.shutdown_request) |-> status.supply_on)
        else $error("shutdown request with the supply switched off");

    a_no_accept_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (status.valid && !status.ready) |-> !accept)
        else $error("sample taken while the result register is full");
`endif

endmodule
